>>> rtl/cdq_pkg.sv
package cdq_pkg;

   localparam int WORD_W        = 32;
   localparam int FUNC_W        = 3;
   localparam int CAP_W         = 5;
   localparam int CAP_RESET     = 16;
   // Largest count the 5-bit capacity register can ask for.
   localparam int CAP_LIMIT     = (1 << CAP_W) - 1;
   localparam int DEPTH_DEFAULT = 16;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [FUNC_W-1:0] func_type;
   typedef logic [CAP_W-1:0]  count_type;

   localparam func_type FUNC_PUSH_FRONT = 3'd0;
   localparam func_type FUNC_PUSH_REAR  = 3'd1;
   localparam func_type FUNC_POP_FRONT  = 3'd2;
   localparam func_type FUNC_POP_REAR   = 3'd3;
   localparam func_type FUNC_NOP        = 3'd4;

   localparam word_type WORD_MINUS_ONE = '1;

   typedef enum logic {
      CDQ_IDLE,
      CDQ_FORM
   } cdq_state_type;

   // Shift/load command broadcast to the cell row.
   typedef struct packed {
      logic shr;   // push front: every cell takes its left neighbor
      logic shl;   // pop front: every cell takes its right neighbor
      logic wr;    // push rear: the cell just past the rear loads the value
   } cdq_ctrl_type;

endpackage

>>> rtl/cdq_cell.sv
module cdq_cell
   import cdq_pkg::*;
(
   input  logic         clock,
   input  cdq_ctrl_type ctrl,
   input  logic         hit,
   input  word_type     push_data,
   input  word_type     left_data,
   input  word_type     right_data,
   output word_type     data_out
);

   word_type data_ff;
   word_type data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.shr) begin
         data_in = left_data;
      end else if (ctrl.shl) begin
         data_in = right_data;
      end else if (ctrl.wr && hit) begin
         data_in = push_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

>>> rtl/circular_deque_core.sv
// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_ready   req_func, req_push_value
// rsp       out        rsp_valid / rsp_ready   rsp_ok, rsp_popped, rsp_front_value,
//                                              rsp_rear_value, rsp_empty_res, rsp_full_res
// csr       in         csr_wr_en (no wait)     csr_wr_data (capacity)
//
// Each request is accepted in CDQ_IDLE, where the count and the cell row are updated,
// and then CDQ_FORM picks the rear cell out of the row and registers the response.
// The response register lets the next request be accepted while a response waits;
// a request finishing while the previous response is still held waits in
// CDQ_FORM until rsp_ready frees the register.
// Synchronous reset empties the deque and sets capacity to 16 (clipped to DEPTH).
// A capacity write also empties the deque; no clearing pass is needed.
module circular_deque_core
   import cdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic signed [WORD_W-1:0] req_push_value,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_ok,
   output logic signed [WORD_W-1:0] rsp_popped,
   output logic signed [WORD_W-1:0] rsp_front_value,
   output logic signed [WORD_W-1:0] rsp_rear_value,
   output logic               rsp_empty_res,
   output logic               rsp_full_res,

   input  logic               csr_wr_en,
   input  logic [CAP_W-1:0]   csr_wr_data
);

   // Only cells that the capacity register can reach are built.
   localparam int NCELL = (DEPTH < CAP_LIMIT) ? DEPTH : CAP_LIMIT;

   // Capacity clamp: zero acts as one, anything above the row acts as the row.
   function automatic count_type clip_cap(input count_type c);
      count_type r;
      r = c;
      if (c == '0) begin
         r = count_type'(1);
      end else if (int'(c) > NCELL) begin
         r = count_type'(NCELL);
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- control
   cdq_state_type state_ff, state_in;
   count_type     cap_ff;
   count_type     count_ff;
   logic          rsp_valid_ff;

   // per-request results held from acceptance until the response is registered
   logic          ok_ff;
   word_type      popped_ff;
   word_type      rear_ff;     // rear value of the current contents

   // response register
   logic          rsp_ok_ff;
   word_type      rsp_popped_ff, rsp_front_ff, rsp_rear_ff;
   logic          rsp_empty_ff, rsp_full_ff;

   logic          accept;
   logic          load_rsp;
   logic          is_push, is_pop, can_push, can_pop, op_ok;
   word_type      popped_in;
   cdq_ctrl_type  ctrl;

   // ---------------------------------------------------------------- cell row
   word_type          cell_data [NCELL];
   logic [NCELL-1:0]  hit_wr;     // cell index equals count: next rear slot
   logic [NCELL-1:0]  tap_rear;   // cell index equals count - 1: current rear
   count_type         count_m1;
   word_type          rear_pick;

   assign count_m1 = count_ff - count_type'(1);

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      word_type left_w, right_w;

      if (i == 0) begin : g_first
         assign left_w = word_type'(req_push_value);
      end else begin : g_mid_l
         assign left_w = cell_data[i-1];
      end

      if (i == NCELL - 1) begin : g_last
         assign right_w = cell_data[i];
      end else begin : g_mid_r
         assign right_w = cell_data[i+1];
      end

      assign hit_wr[i]   = (count_ff == count_type'(i));
      assign tap_rear[i] = (count_m1 == count_type'(i));

      cdq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .hit        (hit_wr[i]),
         .push_data  (word_type'(req_push_value)),
         .left_data  (left_w),
         .right_data (right_w),
         .data_out   (cell_data[i])
      );
   end

   // one-hot pick of the rear cell, over at most 31 cells
   always_comb begin
      rear_pick = '0;
      for (int i = 0; i < NCELL; i++) begin
         rear_pick = rear_pick | (cell_data[i] & {WORD_W{tap_rear[i]}});
      end
   end

   // ---------------------------------------------------------------- decode
   always_comb begin
      is_push  = (req_func == FUNC_PUSH_FRONT) || (req_func == FUNC_PUSH_REAR);
      is_pop   = (req_func == FUNC_POP_FRONT)  || (req_func == FUNC_POP_REAR);
      can_push = is_push && (count_ff < cap_ff);
      can_pop  = is_pop && (count_ff != '0);
      op_ok    = can_push || can_pop;

      ctrl.shr = accept && can_push && (req_func == FUNC_PUSH_FRONT);
      ctrl.wr  = accept && can_push && (req_func == FUNC_PUSH_REAR);
      ctrl.shl = accept && can_pop  && (req_func == FUNC_POP_FRONT);

      popped_in = WORD_MINUS_ONE;
      if (can_pop) begin
         case (req_func)
            FUNC_POP_FRONT: popped_in = cell_data[0];
            FUNC_POP_REAR:  popped_in = rear_ff;
            default:        popped_in = WORD_MINUS_ONE;
         endcase
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         CDQ_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = CDQ_FORM;
            end
         end
         CDQ_FORM: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = CDQ_IDLE;
            end
         end
         default: state_in = CDQ_IDLE;
      endcase
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CDQ_IDLE;
         cap_ff       <= clip_cap(count_type'(CAP_RESET));
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            cap_ff   <= clip_cap(csr_wr_data);
            count_ff <= '0;
         end else if (accept && can_push) begin
            count_ff <= count_ff + count_type'(1);
         end else if (accept && can_pop) begin
            count_ff <= count_m1;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         ok_ff     <= op_ok;
         popped_ff <= popped_in;
      end
      if (load_rsp) begin
         rear_ff       <= rear_pick;
         rsp_ok_ff     <= ok_ff;
         rsp_popped_ff <= popped_ff;
         rsp_empty_ff  <= (count_ff == '0);
         rsp_full_ff   <= (count_ff == cap_ff);
         rsp_front_ff  <= (count_ff == '0) ? WORD_MINUS_ONE : cell_data[0];
         rsp_rear_ff   <= (count_ff == '0) ? WORD_MINUS_ONE : rear_pick;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_popped      = rsp_popped_ff;
   assign rsp_front_value = rsp_front_ff;
   assign rsp_rear_value  = rsp_rear_ff;
   assign rsp_empty_res   = rsp_empty_ff;
   assign rsp_full_res    = rsp_full_ff;

   // ---------------------------------------------------------------- checks
   a_count_in_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap_ff)
      else $error("element count above capacity");

   a_cap_in_row: assert property (@(posedge clock) disable iff (reset)
      (cap_ff != '0) && (int'(cap_ff) <= NCELL))
      else $error("capacity outside the cell row");

   a_accept_forms: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == CDQ_FORM))
      else $error("accepted request not followed by response forming");

   a_empty_response: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |->
         (rsp_front_ff == WORD_MINUS_ONE) && (rsp_rear_ff == WORD_MINUS_ONE) && !rsp_full_ff)
      else $error("empty response carries data or full flag");

   a_one_shift: assert property (@(posedge clock) disable iff (reset)
      $countones({ctrl.shr, ctrl.shl, ctrl.wr}) <= 1)
      else $error("conflicting cell row commands");

endmodule

>>> tb/circular_deque_core_test.sv
`timescale 1ns / 100ps

module circular_deque_core_test;
   import cdq_pkg::*;

   localparam int DEPTH        = DEPTH_DEFAULT;
   localparam int RESET_CYCLES = 11;
   localparam int STALL_LIMIT  = 2000;  // cycles with no handshake on either side
   localparam int HOLD_CYCLES  = 60;    // long receiver hold-off to back the deque up
   localparam int HOLD_AT      = 400;   // requests accepted before the hold-off starts
   localparam int DRAIN_CYCLES = 4;     // margin for the request pipeline to drain
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 246;

   typedef logic [3:0] slot_type;

   // Everything one response carries, in port order.
   typedef struct packed {
      logic     ok;
      word_type popped;
      word_type front_value;
      word_type rear_value;
      logic     empty_res;
      logic     full_res;
   } deque_result_type;

   // Shadow deque plus the queue of responses it has predicted.
   class deque_scoreboard;
      word_type         cells [DEPTH];
      slot_type         head;
      slot_type         tail;
      count_type        fill;
      count_type        cap_reg;
      deque_result_type pending_results [$];
      int               mismatches;
      int               checked;
      int               full_rejects;
      int               empty_pops;
      int               full_hits;

      function new();
         cap_reg = count_type'(CAP_RESET);
         empty_deque();
      endfunction

      function void empty_deque();
         head = '0;
         tail = '0;
         fill = '0;
      endfunction

      function void write_capacity(count_type value);
         cap_reg = value;
         empty_deque();
      endfunction

      // 0 behaves as 1, anything past DEPTH as DEPTH
      function int active_capacity();
         int c;
         c = int'(cap_reg);
         if (c < 1) c = 1;
         if (c > DEPTH) c = DEPTH;
         return c;
      endfunction

      function void note_request(func_type func, word_type value);
         deque_result_type r;
         int               cap;
         cap      = active_capacity();
         r        = '0;
         r.popped = WORD_MINUS_ONE;
         if (func == FUNC_PUSH_FRONT || func == FUNC_PUSH_REAR) begin
            if (int'(fill) < cap) begin
               if (fill == 0) begin
                  // first element always lands in slot 0
                  head     = '0;
                  tail     = '0;
                  cells[0] = value;
               end else if (func == FUNC_PUSH_FRONT) begin
                  head        = (head == 0) ? slot_type'(cap - 1) : head - 1'b1;
                  cells[head] = value;
               end else begin
                  tail        = (int'(tail) + 1 >= cap) ? '0 : tail + 1'b1;
                  cells[tail] = value;
               end
               fill++;
               r.ok = 1'b1;
            end else begin
               full_rejects++;
            end
         end else if (func == FUNC_POP_FRONT || func == FUNC_POP_REAR) begin
            if (fill != 0) begin
               if (func == FUNC_POP_FRONT) begin
                  r.popped = cells[head];
                  head     = (int'(head) + 1 >= cap) ? '0 : head + 1'b1;
               end else begin
                  r.popped = cells[tail];
                  tail     = (tail == 0) ? slot_type'(cap - 1) : tail - 1'b1;
               end
               fill--;
               if (fill == 0) begin
                  head = '0;
                  tail = '0;
               end
               r.ok = 1'b1;
            end else begin
               empty_pops++;
            end
         end
         r.front_value = (fill == 0) ? WORD_MINUS_ONE : cells[head];
         r.rear_value  = (fill == 0) ? WORD_MINUS_ONE : cells[tail];
         r.empty_res   = (fill == 0);
         r.full_res    = (int'(fill) == cap);
         if (r.full_res) full_hits++;
         pending_results.push_back(r);
      endfunction

      function void check_response(deque_result_type got);
         deque_result_type want;
         if (pending_results.size() == 0) begin
            if (mismatches < 10)
               $display("%0t: response with nothing outstanding: %p", $realtime, got);
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         checked++;
         if (got !== want) begin
            if (mismatches < 10) begin
               $display("%0t: response %0d mismatch", $realtime, checked);
               $display("   expected ok=%b popped=%h front=%h rear=%h empty=%b full=%b",
                        want.ok, want.popped, want.front_value, want.rear_value,
                        want.empty_res, want.full_res);
               $display("   actual   ok=%b popped=%h front=%h rear=%h empty=%b full=%b",
                        got.ok, got.popped, got.front_value, got.rear_value,
                        got.empty_res, got.full_res);
            end
            mismatches++;
         end
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction
   endclass

   logic                     clock          = 1'b0;
   logic                     reset          = 1'b1;
   logic                     req_valid      = 1'b0;
   logic                     req_ready;
   logic [FUNC_W-1:0]        req_func       = FUNC_NOP;
   logic signed [WORD_W-1:0] req_push_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready      = 1'b0;
   logic                     rsp_ok;
   logic signed [WORD_W-1:0] rsp_popped;
   logic signed [WORD_W-1:0] rsp_front_value;
   logic signed [WORD_W-1:0] rsp_rear_value;
   logic                     rsp_empty_res;
   logic                     rsp_full_res;
   logic                     csr_wr_en      = 1'b0;
   logic [CAP_W-1:0]         csr_wr_data    = '0;

   deque_scoreboard deque_sb  = new();
   int              requests_accepted;
   int              capacity_writes;
   int              quiet_cycles;
   bit              calm;          // last phase: no idling on either side

   circular_deque_core #(.DEPTH(DEPTH)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ok          (rsp_ok),
      .rsp_popped      (rsp_popped),
      .rsp_front_value (rsp_front_value),
      .rsp_rear_value  (rsp_rear_value),
      .rsp_empty_res   (rsp_empty_res),
      .rsp_full_res    (rsp_full_res),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #4 clock = ~clock;

   // Offer one request and hold it until the deque takes it.
   // Entered and left on a rising edge.
   task automatic send_request(func_type func, word_type value);
      req_valid      <= 1'b1;
      req_func       <= func;
      req_push_value <= value;
      do @(posedge clock); while (!req_ready);
      deque_sb.note_request(func, value);
      requests_accepted++;
   endtask

   task automatic pause_requests(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Capacity may only change with the deque idle: no request in flight,
   // every response back, pipeline drained.
   task automatic set_capacity(count_type value);
      req_valid <= 1'b0;
      while (deque_sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      deque_sb.write_capacity(value);
      capacity_writes++;
      @(posedge clock);
   endtask

   // Mostly full-range random words, sometimes the extremes.
   function automatic word_type pick_value();
      case ($urandom_range(11))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return WORD_MINUS_ONE;
         3:       return '0;
         default: return word_type'($urandom());
      endcase
   endfunction

   // push_pct steers the fill level: above 50 the deque tends to sit full,
   // below 50 it tends to sit empty.
   function automatic func_type pick_func(int push_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < 6)
         return func_type'($urandom_range(7, 4));   // no-op and the unused codes
      if ($urandom_range(99) < push_pct)
         return $urandom_range(1) ? FUNC_PUSH_REAR : FUNC_PUSH_FRONT;
      return $urandom_range(1) ? FUNC_POP_REAR : FUNC_POP_FRONT;
   endfunction

   // Stimulus
   initial begin : requester
      count_type phase_cap [PHASES];
      int        phase_push [PHASES];
      phase_cap  = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd5, 5'd16, 5'd9, 5'd3};
      phase_push = '{50, 55, 50, 60, 65, 45, 55, 50};
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: capacity 2 so both full and empty come up in a handful of requests.
      set_capacity(5'd2);
      send_request(FUNC_POP_FRONT, '0);              // pop on empty
      send_request(FUNC_POP_REAR, 32'hffff_ffff);    // pop on empty
      send_request(FUNC_NOP, 32'h1234_5678);
      send_request(func_type'(3'd5), 32'h0bad_0005); // unused codes act as no-op
      send_request(func_type'(3'd7), 32'h0bad_0007);
      send_request(FUNC_PUSH_FRONT, 32'h7fff_ffff);  // into empty: slot 0
      send_request(FUNC_PUSH_FRONT, 32'h8000_0000);  // head wraps back
      send_request(FUNC_PUSH_REAR, 32'h0000_0001);   // rejected, full
      send_request(FUNC_PUSH_FRONT, 32'h0000_0002);  // rejected, full
      send_request(FUNC_POP_REAR, '0);
      send_request(func_type'(3'd6), '0);
      send_request(FUNC_POP_FRONT, '0);              // last element, indices reset
      send_request(FUNC_PUSH_REAR, '0);
      send_request(FUNC_PUSH_REAR, 32'hffff_ffff);   // tail moves to slot 1
      send_request(FUNC_POP_FRONT, '0);
      send_request(FUNC_PUSH_REAR, 32'h5555_aaaa);   // tail wraps past the end
      send_request(FUNC_POP_REAR, '0);
      send_request(FUNC_POP_REAR, '0);
      send_request(FUNC_POP_REAR, '0);               // empty again
      // capacity write while holding data: deque must come back empty
      send_request(FUNC_PUSH_FRONT, 32'hcafe_f00d);
      set_capacity(5'd16);
      send_request(FUNC_POP_FRONT, '0);

      // Random phases, each under its own capacity, the extremes included.
      for (int p = 0; p < PHASES; p++) begin
         set_capacity(phase_cap[p]);
         if (p == PHASES - 1) calm = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (!calm && $urandom_range(5) == 0)
               pause_requests($urandom_range(11, 1));
            send_request(pick_func(phase_push[p]), pick_value());
         end
      end
      req_valid <= 1'b0;

      while (deque_sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES * 2) @(posedge clock);

      $display("Ran %0d requests under %0d capacity settings, %0d responses checked.",
               requests_accepted, capacity_writes, deque_sb.checked);
      $display("Rejected pushes on full: %0d, pops on empty: %0d, full responses: %0d.",
               deque_sb.full_rejects, deque_sb.empty_pops, deque_sb.full_hits);
      if (deque_sb.mismatches == 0 && deque_sb.outstanding() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", deque_sb.mismatches);
         $display("FAILURE");
      end
      $finish;
   end

   // Response side: random stall bursts, plus one long hold-off so the
   // response register and the pipeline back up into req_ready.
   initial begin : responder
      int  stall_left;
      bit  held;
      stall_left = 0;
      held       = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_valid && rsp_ready)
            deque_sb.check_response('{rsp_ok, rsp_popped, rsp_front_value,
                                      rsp_rear_value, rsp_empty_res, rsp_full_res});
         if (!held && requests_accepted >= HOLD_AT) begin
            held       = 1'b1;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && !calm && $urandom_range(4) == 0) begin
            stall_left = $urandom_range(11, 1);
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   // Watchdog: any handshake on either channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

endmodule

>>> filelist.f
rtl/cdq_pkg.sv
rtl/cdq_cell.sv
rtl/circular_deque_core.sv
tb/circular_deque_core_test.sv
